@@ src/assert_macros.svh @@
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define CEFD_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// consequent must hold at the clock edge after the antecedent
`define CEFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/cefd_pkg.sv @@
// Package for the checksummed encoder frame decoder: constants, codes and types.
// No dependencies.
package cefd_pkg;

	localparam int DATA_BYTES_DEF = 8;
	localparam int STORE_DEPTH    = 8;
	localparam int NUM_SOURCES    = 2;

	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_LOAD  = 1'b1;

	// per-source record kept in RAM
	typedef struct packed {
		logic [31:0]      pos0;
		logic [31:0]      pos1;
		logic [15:0]      d0;
		logic [15:0]      d1;
		logic [3:0][7:0]  analog;
		logic [15:0]      fails;
	} rec_t;

	// read-modify-write request from the byte assembler
	typedef struct packed {
		logic             need;
		logic             is_load;
		logic             addr;
		logic             field;
		logic             ok;
		logic [15:0]      d0;
		logic [15:0]      d1;
		logic [3:0][7:0]  analog;
		logic [31:0]      value;
	} req_t;

endpackage

@@ src/checksummed_encoder_frame_decoder.sv @@
// Top level of the checksummed encoder frame decoder.
// Depends on cefd_pkg, cefd_frame, cefd_update (and through it cefd_ram).
//
// channel  dir  handshake             payload
// in       in   in_valid / in_ready   opcode source start_of_frame data_byte
//                                     encoder_index set_value
// out      out  out_valid / out_ready frame_ok frame_source delta_* position_*
//                                     analog_* error_count
//
// One item per cycle while in_ready is high. A checksum byte's result is registered
// in the update stage, then at the output. The per-source record RAM is read at
// acceptance and written back from the update stage; a back-to-back access to the
// same source takes the forwarded record. No clearing pass: two valid bits cleared
// at reset mark the record RAM entries. in_ready drops only while a result is held
// at the output and a checksum byte waits in the update stage; a load never waits.
module checksummed_encoder_frame_decoder import cefd_pkg::*; #(
	parameter int DATA_BYTES = DATA_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic               source,
	input  logic               start_of_frame,
	input  logic [7:0]         data_byte,
	input  logic [1:0]         encoder_index,
	input  logic signed [31:0] set_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               frame_ok,
	output logic               frame_source,
	output logic signed [15:0] delta_first,
	output logic signed [15:0] delta_second,
	output logic signed [31:0] position_first,
	output logic signed [31:0] position_second,
	output logic [7:0]         analog_zero,
	output logic [7:0]         analog_one,
	output logic [7:0]         analog_two,
	output logic [7:0]         analog_three,
	output logic [15:0]        error_count
);

	logic  accept;
	req_t  req;
	rec_t  out_rec;

	assign accept = in_valid && in_ready;

	cefd_frame #(
		.DATA_BYTES (DATA_BYTES)
	) u_frame (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.opcode         (opcode),
		.source         (source),
		.start_of_frame (start_of_frame),
		.data_byte      (data_byte),
		.encoder_index  (encoder_index),
		.set_value      (set_value),
		.req            (req)
	);

	cefd_update u_update (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.req     (req),
		.ready   (in_ready),
		.out_vld (out_valid),
		.out_rdy (out_ready),
		.out_rec (out_rec),
		.out_ok  (frame_ok),
		.out_src (frame_source)
	);

	assign delta_first     = out_rec.d0;
	assign delta_second    = out_rec.d1;
	assign position_first  = out_rec.pos0;
	assign position_second = out_rec.pos1;
	assign analog_zero     = out_rec.analog[0];
	assign analog_one      = out_rec.analog[1];
	assign analog_two      = out_rec.analog[2];
	assign analog_three    = out_rec.analog[3];
	assign error_count     = out_rec.fails;

endmodule

@@ src/cefd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cefd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/cefd_frame.sv @@
// Byte assembler: frame position, running sum, stored data bytes, request build.
// Depends on cefd_pkg.
module cefd_frame import cefd_pkg::*; #(
	parameter int DATA_BYTES = DATA_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic        opcode,
	input  logic        source,
	input  logic        start_of_frame,
	input  logic [7:0]  data_byte,
	input  logic [1:0]  encoder_index,
	input  logic [31:0] set_value,
	output req_t        req
);

	localparam int PW = $clog2(DATA_BYTES + 1);

	logic [PW-1:0] pos_q;
	logic [7:0]    sum_q;
	logic          src_q;
	logic [7:0]    frame_q [STORE_DEPTH];

	logic [PW-1:0] p_eff;
	logic [7:0]    sum_eff;
	logic          src_eff;
	logic          in_frame;
	logic          chk;

	assign p_eff    = start_of_frame ? '0 : pos_q;
	assign sum_eff  = start_of_frame ? 8'd0 : sum_q;
	assign src_eff  = start_of_frame ? source : src_q;
	assign in_frame = p_eff < PW'(DATA_BYTES);
	assign chk      = (opcode == OP_FRAME) && !in_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
			src_q <= 1'b0;
		end else if (accept && opcode == OP_FRAME) begin
			src_q <= src_eff;
			if (in_frame) begin
				pos_q <= p_eff + PW'(1);
				sum_q <= sum_eff + data_byte;
			end else begin
				pos_q <= '0;
				sum_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && opcode == OP_FRAME && in_frame
				&& {1'b0, p_eff} < (PW+1)'(STORE_DEPTH)) begin
			frame_q[p_eff[2:0]] <= data_byte;
		end
	end

	always_comb begin
		req         = '0;
		req.need    = (opcode == OP_LOAD) || chk;
		req.is_load = (opcode == OP_LOAD);
		req.addr    = (opcode == OP_LOAD) ? encoder_index[1] : src_q;
		req.field   = encoder_index[0];
		req.ok      = (sum_eff == data_byte);
		req.d0      = {frame_q[0], frame_q[1]};
		req.d1      = {frame_q[2], frame_q[3]};
		req.value   = set_value;
		for (int k = 0; k < 4; k++) begin
			req.analog[k] = (4 + k < DATA_BYTES) ? frame_q[4 + k] : 8'd0;
		end
	end

endmodule

@@ src/cefd_update.sv @@
// Source record read-modify-write stage with forwarding, and output register.
// Depends on cefd_pkg and cefd_ram.
module cefd_update import cefd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  req_t  req,
	output logic  ready,
	output logic  out_vld,
	input  logic  out_rdy,
	output rec_t  out_rec,
	output logic  out_ok,
	output logic  out_src
);

	req_t  req_s1;
	logic  vld_s1;
	logic  rvld_s1;
	logic  [NUM_SOURCES-1:0] ent_vld_q;
	rec_t  fwd_q;
	logic  fwd_addr_q;
	logic  fwd_en_q;
	logic  out_vld_q;

	logic  raddr;
	rec_t  rdata;
	rec_t  cur;
	rec_t  nxt;
	logic  go;

	assign go    = vld_s1 && (req_s1.is_load || !out_vld_q || out_rdy);
	assign ready = !vld_s1 || go;
	assign raddr = (accept && req.need) ? req.addr : req_s1.addr;

	cefd_ram #(
		.WIDTH ($bits(rec_t)),
		.DEPTH (NUM_SOURCES)
	) u_ram (
		.clk   (clk),
		.we    (go),
		.waddr (req_s1.addr),
		.wdata (nxt),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		if (fwd_en_q && fwd_addr_q == req_s1.addr) begin
			cur = fwd_q;
		end else if (rvld_s1) begin
			cur = rdata;
		end else begin
			cur = '0;
		end
	end

	always_comb begin
		nxt = cur;
		if (req_s1.is_load) begin
			if (req_s1.field) begin
				nxt.pos1 = req_s1.value;
			end else begin
				nxt.pos0 = req_s1.value;
			end
		end else if (req_s1.ok) begin
			nxt.d0     = req_s1.d0;
			nxt.d1     = req_s1.d1;
			nxt.pos0   = cur.pos0 + {{16{req_s1.d0[15]}}, req_s1.d0};
			nxt.pos1   = cur.pos1 + {{16{req_s1.d1[15]}}, req_s1.d1};
			nxt.analog = req_s1.analog;
		end else if (cur.fails != 16'hFFFF) begin
			nxt.fails = cur.fails + 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			rvld_s1   <= 1'b0;
			ent_vld_q <= '0;
			fwd_en_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			rvld_s1  <= ent_vld_q[raddr];
			fwd_en_q <= go;
			if (accept && req.need) begin
				vld_s1 <= 1'b1;
			end else if (go) begin
				vld_s1 <= 1'b0;
			end
			if (go) begin
				ent_vld_q[req_s1.addr] <= 1'b1;
			end
			if (go && !req_s1.is_load) begin
				out_vld_q <= 1'b1;
			end else if (out_rdy) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.need) begin
			req_s1 <= req;
		end
		if (go) begin
			fwd_q      <= nxt;
			fwd_addr_q <= req_s1.addr;
		end
		if (go && !req_s1.is_load) begin
			out_rec <= nxt;
			out_ok  <= req_s1.ok;
			out_src <= req_s1.addr;
		end
	end

	assign out_vld = out_vld_q;

endmodule

@@ src/cefd_checker.sv @@
// Port-level checker for the checksummed encoder frame decoder, bound to the top.
// Depends on cefd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cefd_checker import cefd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        opcode,
	input logic        out_valid,
	input logic        out_ready,
	input logic        frame_ok,
	input logic        frame_source,
	input logic [31:0] position_first,
	input logic [15:0] error_count
);

	`CEFD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(frame_ok) && $stable(frame_source) && $stable(position_first) && $stable(error_count), "stalled result changed")
	`CEFD_ASSERT(a_latency, clk, arst_n, $rose(out_valid) |-> $past(in_valid && in_ready && opcode == OP_FRAME, 2), "result without a frame byte two cycles before")
	`CEFD_ASSERT(a_fail_count, clk, arst_n, out_valid && !frame_ok |-> error_count != 16'd0, "rejected frame with zero error count")
	`CEFD_ASSERT(a_backpressure, clk, arst_n, !in_ready |-> out_valid && !out_ready, "input stalled without output stall")

endmodule

bind checksummed_encoder_frame_decoder cefd_checker u_cefd_checker (.*);
